[hdl/brm_pkg.sv]
// shared types and default sizes for the block rms meter
package brm_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic mul;
    logic acc;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;
    logic out_full;
  } sts_t;

endpackage

[hdl/brm_in_if.sv]
// sample channel of the block rms meter
interface brm_in_if #(
  parameter int unsigned SAMPLE_BITS = brm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

[hdl/brm_out_if.sv]
// result channel of the block rms meter
interface brm_out_if #(
  parameter int unsigned SAMPLE_BITS = brm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned MAX_SAMPLES = brm_pkg::MAX_SAMPLES_DEF
);
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] rms;
  logic [CntW-1:0]        sample_count;
  logic                   overflow;

  modport source (output valid, output rms, output sample_count, output overflow, input ready);
  modport sink   (input valid, input rms, input sample_count, input overflow, output ready);
endinterface

[hdl/brm_datapath.sv]
// square, accumulate, divide, square root and output register
module brm_datapath #(
  parameter int unsigned SAMPLE_BITS = brm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned MAX_SAMPLES = brm_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  brm_pkg::cmd_t                                cmd_i,
  output brm_pkg::sts_t                                sts_o,
  input  logic signed [SAMPLE_BITS-1:0]                sample_i,
  input  logic                                         last_i,
  input  logic                                         out_ready_i,
  output logic                                         out_valid_o,
  output logic [SAMPLE_BITS-1:0]                       rms_o,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]             sample_count_o,
  output logic                                         overflow_o
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned CntW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumW   = 2 * SB - 1 + $clog2(MAX_SAMPLES);
  localparam int unsigned RadW   = 2 * SB;
  localparam int unsigned DremW  = CntW + 1;
  localparam int unsigned SremW  = SB + 2;
  localparam logic [CntW-1:0] MaxCount = CntW'(MAX_SAMPLES);

  logic [SB-1:0]     mag_d, mag_q;
  logic              last_q;
  logic [2*SB-1:0]   prod_d, prod_q;
  logic [SumW-1:0]   sum_q;
  logic [CntW-1:0]   count_q;
  logic              ovf_q;
  logic [SumW-1:0]   quo_q;
  logic [DremW-1:0]  drem_q, dtrial;
  logic              dge;
  logic [RadW-1:0]   rad_q;
  logic [SB-1:0]     root_q;
  logic [SremW-1:0]  srem_q, strial_rem, strial;
  logic              sge;
  logic              out_valid_q;
  logic [SB-1:0]     rms_q;
  logic [CntW-1:0]   cnt_out_q;
  logic              ovf_out_q;

  // magnitude of the two's complement sample, most negative maps to 2^(SB-1)
  assign mag_d  = sample_i[SB-1] ? (~sample_i + SB'(1)) : sample_i;
  assign prod_d = mag_q * mag_q;

  // restoring divide, one quotient bit per step
  assign dtrial = {drem_q[CntW-1:0], quo_q[SumW-1]};
  assign dge    = (dtrial >= {1'b0, count_q});

  // digit-by-digit square root, two radicand bits per step
  assign strial_rem = {srem_q[SB-1:0], rad_q[RadW-1 -: 2]};
  assign strial     = {root_q, 2'b01};
  assign sge        = (strial_rem >= strial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mag_q  <= mag_d;
      last_q <= last_i;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.div_init) begin
      quo_q  <= sum_q;
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[SumW-2:0], dge};
      drem_q <= dge ? (dtrial - {1'b0, count_q}) : dtrial;
    end
    if (cmd_i.sqrt_init) begin
      rad_q  <= RadW'(quo_q);
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      root_q <= {root_q[SB-2:0], sge};
      srem_q <= sge ? (strial_rem - strial) : strial_rem;
    end
    if (cmd_i.out_load) begin
      rms_q     <= root_q;
      cnt_out_q <= count_q;
      ovf_out_q <= ovf_q;
    end
  end

  // block state, cleared when the result moves to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.out_load) begin
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.acc) begin
      if (count_q < MaxCount) begin
        sum_q   <= sum_q + SumW'(prod_q);
        count_q <= count_q + CntW'(1);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.out_full = out_valid_q;

  assign out_valid_o    = out_valid_q;
  assign rms_o          = rms_q;
  assign sample_count_o = cnt_out_q;
  assign overflow_o     = ovf_out_q;

endmodule

[hdl/brm_ctrl.sv]
// sequencer for the block rms meter
module brm_ctrl #(
  parameter int unsigned SAMPLE_BITS = brm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned MAX_SAMPLES = brm_pkg::MAX_SAMPLES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  brm_pkg::sts_t sts_i,
  output brm_pkg::cmd_t cmd_o
);

  localparam int unsigned DivSteps  = 2 * SAMPLE_BITS - 1 + $clog2(MAX_SAMPLES);
  localparam int unsigned SqrtSteps = SAMPLE_BITS;
  localparam int unsigned StepW     = $clog2(DivSteps);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_DINIT = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SINIT = 3'd5;
  localparam logic [2:0] S_SQRT  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_d, state_q;
  logic [StepW-1:0] step_d, step_q;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.last ? S_DINIT : S_IDLE;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + StepW'(1);
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = S_SINIT;
        end
      end
      S_SINIT: begin
        cmd_o.sqrt_init = 1'b1;
        step_d          = '0;
        state_d         = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        step_d          = step_q + StepW'(1);
        if (step_q == StepW'(SqrtSteps - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

[hdl/block_rms_meter_unit.sv]
// top level of the block rms meter
//
// in_i carries signed samples with a last flag; out_o carries one result per
// block: rms (unsigned, same fixed point as the input), sample_count and
// overflow. A transfer happens on a clock edge with valid and ready high.
// Each sample passes through capture, the square in the multiplier and the
// accumulate, and in_i takes no new sample until it has been accumulated.
// After the last sample of a block the restoring divider runs one step per
// sum bit (2*SAMPLE_BITS-1+clog2(MAX_SAMPLES), 41 by default) and the root
// unit one step per result bit (SAMPLE_BITS); the result then waits to be
// loaded into the output register that drives out_o.
// Samples past MAX_SAMPLES in a block are dropped and flag overflow.
// Results wait in an output register; if out_o stalls, the next block is
// still taken in and waits before loading until the register is taken.
// Reset (rst_ni low, asynchronous) clears the sum, count, state and out valid.
module block_rms_meter_unit #(
  parameter int unsigned MAX_SAMPLES = brm_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = brm_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  brm_in_if.sink    in_i,
  brm_out_if.source out_o
);

  brm_pkg::cmd_t cmd;
  brm_pkg::sts_t sts;

  brm_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  brm_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_i       (in_i.sample),
    .last_i         (in_i.last),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .rms_o          (out_o.rms),
    .sample_count_o (out_o.sample_count),
    .overflow_o     (out_o.overflow)
  );

endmodule

[hdl/brm_checker.sv]
// port checks for the block rms meter, bound to the top level
module brm_checker #(
  parameter int unsigned MAX_SAMPLES = brm_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = brm_pkg::SAMPLE_BITS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [SAMPLE_BITS-1:0]           rms_i,
  input logic [$clog2(MAX_SAMPLES+1)-1:0] sample_count_i,
  input logic                             overflow_i
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CntW-1:0]        MaxCount = CntW'(MAX_SAMPLES);
  localparam logic [SAMPLE_BITS-1:0] MaxRms   = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(rms_i) &&
      $stable(sample_count_i) && $stable(overflow_i))
    else $error("result changed while stalled");

  // each accepted sample keeps the input closed while it is squared and accumulated
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i)
    else $error("sample taken before accumulate finished");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> sample_count_i != '0 && sample_count_i <= MaxCount)
    else $error("sample count out of range");

  // a truncated block always holds the full count
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overflow_i |-> sample_count_i == MaxCount)
    else $error("overflow without full block");

  a_rms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> rms_i <= MaxRms)
    else $error("rms above full scale");

endmodule

bind block_rms_meter_unit brm_checker #(
  .MAX_SAMPLES(MAX_SAMPLES),
  .SAMPLE_BITS(SAMPLE_BITS)
) u_brm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .rms_i          (out_o.rms),
  .sample_count_i (out_o.sample_count),
  .overflow_i     (out_o.overflow)
);

[bench/tb_top.sv]
// self-checking testbench for the block rms meter: directed rows, random blocks, an overflow block
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned SampleW = brm_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned MaxBlock = brm_pkg::MAX_SAMPLES_DEF;
  localparam int unsigned CntW = $clog2(brm_pkg::MAX_SAMPLES_DEF + 1);
  localparam int unsigned SumW = 2 * SampleW - 1 + $clog2(brm_pkg::MAX_SAMPLES_DEF);
  localparam int RandomItems = 450;
  localparam int DrainCycles = 100;

  typedef struct packed {
    logic [SampleW-1:0] rms;
    logic [CntW-1:0]    cnt;
    logic               ovf;
  } rms_res_t;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last;
    logic               typed;
    rms_res_t           res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  brm_in_if  #(.SAMPLE_BITS(SampleW)) in_if ();
  brm_out_if #(.SAMPLE_BITS(SampleW), .MAX_SAMPLES(MaxBlock)) out_if ();

  block_rms_meter_unit #(
    .MAX_SAMPLES(MaxBlock),
    .SAMPLE_BITS(SampleW)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // block state of the predictor
  logic [SumW-1:0] sq_sum;
  logic [CntW-1:0] n_acc;
  logic            dropped;

  rms_res_t rms_expect_q[$];
  int       mismatch_count;
  int       items_sent;

  // rows with a typed result are obvious by hand; the others go through the predictor
  stim_row_t directed_rows [17] = '{
    '{16'h0000, 1'b1, 1'b1, '{16'd0,     11'd1, 1'b0}},
    '{16'h7fff, 1'b1, 1'b1, '{16'd32767, 11'd1, 1'b0}},
    '{16'h8000, 1'b1, 1'b1, '{16'd32768, 11'd1, 1'b0}},
    '{16'hffff, 1'b1, 1'b1, '{16'd1,     11'd1, 1'b0}},
    '{16'h5555, 1'b0, 1'b0, '0},
    '{16'haaaa, 1'b1, 1'b0, '0},
    '{16'h8000, 1'b0, 1'b0, '0},
    '{16'h8000, 1'b0, 1'b0, '0},
    '{16'h8000, 1'b0, 1'b0, '0},
    '{16'h8000, 1'b1, 1'b1, '{16'd32768, 11'd4, 1'b0}},
    '{16'd100,  1'b0, 1'b0, '0},
    '{16'hff9c, 1'b0, 1'b0, '0},
    '{16'h0000, 1'b1, 1'b0, '0},
    '{16'h7fff, 1'b0, 1'b0, '0},
    '{16'h8000, 1'b1, 1'b0, '0},
    '{16'h0001, 1'b0, 1'b0, '0},
    '{16'h0000, 1'b1, 1'b1, '{16'd0,     11'd2, 1'b0}}
  };

  // largest r with r*r <= v
  function automatic logic [SampleW-1:0] floor_root(input logic [SumW-1:0] v);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int b = SampleW; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= 64'(v)) r = trial;
    end
    return r[SampleW-1:0];
  endfunction

  // add one sample to the block; returns 1 and the result when the block closes
  function automatic bit accumulate_sample(input logic [SampleW-1:0] s, input logic l,
                                           output rms_res_t res);
    logic signed [31:0] sq;
    logic [SumW-1:0]    mean;
    sq = 32'($signed(s)) * 32'($signed(s));
    if (n_acc < CntW'(MaxBlock)) begin
      sq_sum = sq_sum + SumW'($unsigned(sq));
      n_acc  = n_acc + CntW'(1);
    end else begin
      dropped = 1'b1;
    end
    res = '0;
    if (!l) return 1'b0;
    mean    = (n_acc != 0) ? sq_sum / SumW'(n_acc) : '0;
    res.rms = floor_root(mean);
    res.cnt = n_acc;
    res.ovf = dropped;
    sq_sum  = '0;
    n_acc   = '0;
    dropped = 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    if (r < 30) return 16'($urandom_range(0, 255)) ^ ($urandom_range(0, 1) ? 16'hffff : 16'h0000);
    return 16'($urandom());
  endfunction

  function automatic int pick_block_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 64);
    return $urandom_range(65, 300);
  endfunction

  // one sample transfer; valid stays high across back-to-back samples
  task automatic push_sample(input logic [SampleW-1:0] s, input logic l, input int gap,
                             input logic typed, input rms_res_t typed_res);
    rms_res_t res;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    in_if.last   <= l;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    if (accumulate_sample(s, l, res)) rms_expect_q.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (rms_expect_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_block(input int len, input bit all_min);
    for (int i = 0; i < len; i++)
      push_sample(all_min ? 16'h8000 : pick_sample(), i == len - 1, pick_gap(), 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    rms_res_t got;
    rms_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.rms, out_if.sample_count, out_if.overflow};
      if (rms_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: rms=%0d count=%0d overflow=%0b",
                   got.rms, got.cnt, got.ovf);
      end else begin
        want = rms_expect_q.pop_front();
        if (got.rms !== want.rms || got.cnt !== want.cnt || got.ovf !== want.ovf) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: rms %0d/%0d count %0d/%0d overflow %0b/%0b (exp/act)",
                     want.rms, got.rms, want.cnt, got.cnt, want.ovf, got.ovf);
        end
      end
    end
  end

  // result side: runs of ready with short or long stalls in between
  initial begin
    int run_len;
    int stall_len;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      run_len   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(50, 200);
      stall_len = $urandom_range(0, 99);
      stall_len = (stall_len < 55) ? 0 :
                  (stall_len < 90) ? $urandom_range(1, 3) : $urandom_range(20, 120);
      out_if.ready <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      if (stall_len > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

  initial begin
    sq_sum         = '0;
    n_acc          = '0;
    dropped        = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    in_if.last   <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      push_sample(directed_rows[i].sample, directed_rows[i].last, pick_gap(),
                  directed_rows[i].typed, directed_rows[i].res);
    // hold the sender until every block so far has been reported
    drain_results();

    items_sent = 0;
    while (items_sent < RandomItems) send_block(pick_block_len(), 1'b0);
    drain_results();

    // full-scale block one sample past the bound, then a short one
    send_block(MaxBlock + 1, 1'b1);
    send_block(3, 1'b0);

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
